### design/itaf_pkg.sv
// Shared types, codes and character constants for the integer-to-ASCII formatter.
package itaf_pkg;

  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_HEX  = 3'd2,
    CMD_BIN  = 3'd3,
    CMD_CHAR = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_TRIM,
    ST_SIZE,
    ST_PAD,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic trim;
    logic size;
    logic emit_pad;
    logic emit_sign;
    logic emit_digit;
  } ctrl_t;

  typedef struct packed {
    logic dabble_last;
    logic trim_done;
    logic pad_zero;
    logic pad_one;
    logic neg;
    logic dig_zero;
    logic dig_one;
  } stat_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [8*16-1:0] HEX_DIGITS = "0123456789abcdef";

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    digit_ascii = HEX_DIGITS[8*(15-d) +: 8];
  endfunction

endpackage

### design/itaf_ctrl.sv
// Sequencer for the formatter: load, BCD conversion, zero trim, sizing, emission.
module itaf_ctrl
  import itaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_command,
  input  stat_t      stat,
  output ctrl_t      ctrl,
  output logic       busy
);

  state_t state_r, state_nxt;
  logic   cmd_ok;

  assign cmd_ok = (in_command <= CMD_CHAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (cmd_t'(in_command))
            CMD_SDEC, CMD_UDEC: state_nxt = ST_DABBLE;
            CMD_HEX, CMD_BIN:   state_nxt = ST_TRIM;
            CMD_CHAR:           state_nxt = ST_SIZE;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DABBLE: begin
        if (stat.dabble_last) state_nxt = ST_TRIM;
      end
      ST_TRIM: begin
        if (stat.trim_done) state_nxt = ST_SIZE;
      end
      ST_SIZE: state_nxt = ST_PAD;
      ST_PAD: begin
        if (stat.pad_zero || stat.pad_one) begin
          if (stat.neg)           state_nxt = ST_SIGN;
          else if (stat.dig_zero) state_nxt = ST_IDLE;
          else                    state_nxt = ST_DIGIT;
        end
      end
      ST_SIGN: state_nxt = ST_DIGIT;
      ST_DIGIT: begin
        if (stat.dig_one) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.load       = (state_r == ST_IDLE) && start && cmd_ok;
    ctrl.dabble     = (state_r == ST_DABBLE);
    ctrl.trim       = (state_r == ST_TRIM) && !stat.trim_done;
    ctrl.size       = (state_r == ST_SIZE);
    ctrl.emit_pad   = (state_r == ST_PAD) && !stat.pad_zero;
    ctrl.emit_sign  = (state_r == ST_SIGN);
    ctrl.emit_digit = (state_r == ST_DIGIT);
    busy            = (state_r != ST_IDLE);
  end

endmodule

### design/itaf_dp.sv
// Datapath: operand load, shift-add-3 BCD conversion, text shifter and output beat register.
module itaf_dp
  import itaf_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 ctrl,
  input  logic [2:0]            in_command,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [4:0]            in_width,
  output stat_t                 stat,
  output logic                  out_valid,
  output logic [7:0]            out_character,
  output logic                  out_last
);

  localparam int NDEC = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int NHEX = (VALUE_BITS + 3) / 4;
  localparam int TW   = 4 * NDEC;
  localparam int HSH  = TW - 4 * NHEX;
  localparam int BSH  = TW - VALUE_BITS;
  localparam int BW   = $clog2(VALUE_BITS);
  localparam int LW   = $clog2(VALUE_BITS + 2);
  localparam int PW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = (PW > 5) ? PW : 5;
  localparam int SW   = (LW > PW) ? LW : PW;

  cmd_t                  mode_r, mode_nxt;
  logic [TW-1:0]         txt_r, txt_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic [LW-1:0]         dig_r, dig_nxt;
  logic                  neg_r, neg_nxt;
  logic [PW-1:0]         wid_r, wid_nxt;
  logic [PW-1:0]         pad_r, pad_nxt;
  logic                  valid_r, valid_nxt;
  logic [7:0]            char_r, char_nxt;
  logic                  last_r, last_nxt;

  cmd_t                  cmd_in;
  logic                  vneg;
  logic [VALUE_BITS-1:0] mag;
  logic [7:0]            byte_in;
  logic [CW-1:0]         wext, wsat;
  logic [TW-1:0]         corr;
  logic [3:0]            topd;
  logic                  top_nz;
  logic [SW-1:0]         len_ext, wid_ext;

  assign cmd_in  = cmd_t'(in_command);
  assign vneg    = (cmd_in == CMD_SDEC) && in_value[VALUE_BITS-1];
  assign mag     = vneg ? (~in_value + 1'b1) : in_value;
  assign byte_in = in_value[7:0];
  assign wext    = CW'(in_width);
  assign wsat    = (wext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : wext;

  assign topd    = (mode_r == CMD_BIN) ? {3'b000, txt_r[TW-1]} : txt_r[TW-1 -: 4];
  assign top_nz  = (topd != 4'd0);
  assign len_ext = SW'(dig_r) + SW'(neg_r);
  assign wid_ext = SW'(wid_r);

  // add 3 to every BCD digit of five or more before the shift
  always_comb begin
    corr = txt_r;
    for (int i = 0; i < NDEC; i++) begin
      if (txt_r[4*i +: 4] >= 4'd5) corr[4*i +: 4] = txt_r[4*i +: 4] + 4'd3;
    end
  end

  always_comb begin
    stat             = '0;
    stat.dabble_last = (bit_r == BW'(VALUE_BITS - 1));
    stat.trim_done   = (dig_r == LW'(1)) || top_nz;
    stat.pad_zero    = (pad_r == '0);
    stat.pad_one     = (pad_r == PW'(1));
    stat.neg         = neg_r;
    stat.dig_zero    = (dig_r == '0);
    stat.dig_one     = (dig_r == LW'(1));
  end

  always_comb begin
    mode_nxt  = mode_r;
    txt_nxt   = txt_r;
    bin_nxt   = bin_r;
    bit_nxt   = bit_r;
    dig_nxt   = dig_r;
    neg_nxt   = neg_r;
    wid_nxt   = wid_r;
    pad_nxt   = pad_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;

    if (ctrl.load) begin
      mode_nxt = cmd_in;
      neg_nxt  = vneg;
      bin_nxt  = mag;
      bit_nxt  = '0;
      wid_nxt  = PW'(wsat);
      case (cmd_in)
        CMD_SDEC, CMD_UDEC: begin
          txt_nxt = '0;
          dig_nxt = LW'(NDEC);
        end
        CMD_HEX: begin
          txt_nxt = TW'(in_value) << HSH;
          dig_nxt = LW'(NHEX);
        end
        CMD_BIN: begin
          txt_nxt = TW'(in_value) << BSH;
          dig_nxt = LW'(VALUE_BITS);
        end
        CMD_CHAR: begin
          txt_nxt = TW'(byte_in) << (TW - 8);
          dig_nxt = LW'(byte_in != 8'd0);
          // a zero byte drops itself and one padding space
          if (byte_in == 8'd0) wid_nxt = (wsat != '0) ? PW'(wsat - 1'b1) : '0;
        end
        default: begin
          txt_nxt = '0;
          dig_nxt = '0;
        end
      endcase
    end

    if (ctrl.dabble) begin
      txt_nxt = {corr[TW-2:0], bin_r[VALUE_BITS-1]};
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      bit_nxt = bit_r + 1'b1;
    end

    if (ctrl.trim || ctrl.emit_digit) begin
      txt_nxt = (mode_r == CMD_BIN) ? (txt_r << 1) : (txt_r << 4);
      dig_nxt = dig_r - 1'b1;
    end

    if (ctrl.size) begin
      pad_nxt = (wid_ext > len_ext) ? PW'(wid_ext - len_ext) : '0;
    end

    if (ctrl.emit_pad) begin
      pad_nxt   = pad_r - 1'b1;
      valid_nxt = 1'b1;
      char_nxt  = CH_SPACE;
      last_nxt  = (pad_r == PW'(1)) && !neg_r && (dig_r == '0);
    end

    if (ctrl.emit_sign) begin
      valid_nxt = 1'b1;
      char_nxt  = CH_MINUS;
      last_nxt  = (dig_r == '0);
    end

    if (ctrl.emit_digit) begin
      valid_nxt = 1'b1;
      char_nxt  = (mode_r == CMD_CHAR) ? txt_r[TW-1 -: 8] : digit_ascii(topd);
      last_nxt  = (dig_r == LW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    txt_r  <= txt_nxt;
    bin_r  <= bin_nxt;
    bit_r  <= bit_nxt;
    dig_r  <= dig_nxt;
    neg_r  <= neg_nxt;
    wid_r  <= wid_nxt;
    pad_r  <= pad_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

### design/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter: one operand in, its padded text out one character per beat.
// Decimal operands are first converted to BCD; decimal, hex and binary text then drops its
// leading zero digits but keeps at least one; the field is sized, then spaces, sign and digits go out.
// A new operand is accepted only in idle, once the previous item is done; the rate is set by
// the one-bit-per-cycle BCD shifter and the one-character-per-cycle output register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and clears out_valid.
// Each beat shows for exactly one cycle on out_valid; the receiver cannot stall it.
module integer_to_ascii_formatter
  import itaf_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_command,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [4:0]            in_width,
  output logic                  out_valid,
  output logic [7:0]            out_character,
  output logic                  out_last
);

  ctrl_t ctrl;
  stat_t stat;

  itaf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .ctrl       (ctrl),
    .busy       (busy)
  );

  itaf_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_width      (in_width),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // a beat that is not the last one leaves the sequencer still at work
  a_mid_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("non-last beat while idle");

  // the next item cannot produce a beat right after a last beat
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("beat directly after last beat");

  // unused command codes are dropped without starting work
  a_bad_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command > CMD_CHAR)) |=> !busy)
    else $error("unused command started work");

  // idle sequencer issues no beat in the following cycle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !out_valid)
    else $error("beat without work in flight");

endmodule
